// File: rtl/pcm_pkg.sv
package pcm_pkg;

   localparam int CORRIDOR_DEPTH = 64;
   localparam int VISITED_DEPTH  = 16;

   localparam int HANDLE_W = 64;
   localparam int POS_W    = 6;
   localparam int LEN_W    = 7;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // corridor address and count widths
   localparam int C_AW = $clog2(CORRIDOR_DEPTH);
   localparam int C_CW = $clog2(CORRIDOR_DEPTH + 1);
   // visited address and count widths
   localparam int V_AW = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
   localparam int V_CW = $clog2(VISITED_DEPTH + 1);
   // common width for merge bookkeeping arithmetic
   localparam int CV_W = (C_CW > V_CW) ? C_CW : V_CW;
   localparam int N_W  = ((CV_W > POS_W) ? CV_W : POS_W) + 1;

   localparam logic [KIND_W-1:0] KIND_APPEND_CORRIDOR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND_VISITED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ            = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR           = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] poly_ref;
      logic [POS_W-1:0]    position;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]    corridor_length;
      logic [HANDLE_W-1:0] entry_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CRD,
      ST_VCMP,
      ST_MRD,
      ST_MWR,
      ST_VRD,
      ST_VWR,
      ST_DONE
   } state_type;

endpackage

// File: rtl/path_corridor_merge.sv
// Path corridor merge: keeps a corridor of polygon handles and a buffer of
// visited handles in two single-port synchronous memories.
// Request channel (req_valid / req_stall / req): append corridor entry, append
// visited entry (last starts the merge), read corridor entry, or clear.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one response per
// request, in order, from an output register.
// One request is worked on at a time; req_stall is high from acceptance until
// the result has moved into the output register, which may still be held by
// the receiver while the next request is accepted.
// Appends, clear and out-of-range reads go straight to the done state; an
// in-range read passes through the read state first. The block is back in
// idle as the response is registered. A merge walks the corridor from its
// end, reading each entry and comparing it with the visited entries one at a
// time, then copies each kept tail entry and each reversed visited entry with
// a read state and a write state on the corridor port.
// A stalled receiver holds the finished result in the block until rsp frees.
// Reset empties both lists and the output register; no clearing pass is made.
module path_corridor_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcm_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcm_pkg::rsp_type rsp
);

   localparam int C_AW = pcm_pkg::C_AW;
   localparam int C_CW = pcm_pkg::C_CW;
   localparam int V_AW = pcm_pkg::V_AW;
   localparam int V_CW = pcm_pkg::V_CW;
   localparam int N_W  = pcm_pkg::N_W;
   localparam int HW   = pcm_pkg::HANDLE_W;
   localparam logic [N_W-1:0] C_DEPTH = N_W'(pcm_pkg::CORRIDOR_DEPTH);
   localparam logic [N_W-1:0] V_DEPTH = N_W'(pcm_pkg::VISITED_DEPTH);

   // memories
   logic [HW-1:0] cor_mem [pcm_pkg::CORRIDOR_DEPTH];
   logic [HW-1:0] vis_mem [pcm_pkg::VISITED_DEPTH];
   logic [HW-1:0] cor_rd_ff;
   logic [HW-1:0] vis_rd_ff;
   logic            cor_we, cor_re, vis_we, vis_re;
   logic [C_AW-1:0] cor_wa, cor_ra;
   logic [V_AW-1:0] vis_wa, vis_ra;
   logic [HW-1:0]   cor_wd, vis_wd;

   pcm_pkg::state_type state_ff, state_in;
   logic [C_CW-1:0] cc_ff, cc_in;
   logic [V_CW-1:0] vc_ff, vc_in;
   logic [C_AW-1:0] ci_ff, ci_in;
   logic [V_AW-1:0] vj_ff, vj_in;
   logic [N_W-1:0]  need_ff, need_in, keep_ff, keep_in, from_ff, from_in, k_ff, k_in;
   logic            desc_ff, desc_in;
   logic            drop_ff, drop_in;
   logic [HW-1:0]   res_entry_ff, res_entry_in;
   logic [pcm_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   pcm_pkg::rsp_type rsp_ff, rsp_in;

   logic            req_fire, rsp_free;
   logic [N_W-1:0]  cc_n, vc_n, pos_n, vc_after_n;
   logic            cor_full, vis_full, rd_ok, can_merge;
   logic            hit, vj_more, ci_zero, mv_last, vw_last;
   logic [N_W-1:0]  need_c, from_c, keep_c, need_p, keep_p;
   logic [N_W-1:0]  mv_src, mv_dst, vis_src, new_len;

   assign req_stall = (state_ff != pcm_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign cc_n       = N_W'(cc_ff);
   assign vc_n       = N_W'(vc_ff);
   assign pos_n      = N_W'(req.position);
   assign cor_full   = (cc_n >= C_DEPTH);
   assign vis_full   = (vc_n >= V_DEPTH);
   assign vc_after_n = vis_full ? vc_n : vc_n + N_W'(1);
   assign rd_ok      = (pos_n < cc_n) && (pos_n < C_DEPTH);
   assign can_merge  = (cc_n != '0) && (vc_after_n != '0);

   assign hit     = (cor_rd_ff == vis_rd_ff);
   assign vj_more = (N_W'(vj_ff) + N_W'(1)) < vc_n;
   assign ci_zero = (ci_ff == '0);
   assign mv_last = (k_ff + N_W'(1)) == keep_ff;
   assign vw_last = (k_ff + N_W'(1)) == need_ff;
   assign new_len = need_ff + keep_ff;

   // tail move runs top-down when the tail shifts toward the end
   assign mv_src  = desc_ff ? from_ff + keep_ff - N_W'(1) - k_ff : from_ff + k_ff;
   assign mv_dst  = desc_ff ? need_ff + keep_ff - N_W'(1) - k_ff : need_ff + k_ff;
   assign vis_src = vc_n - N_W'(1) - k_ff;

   // placement of the rebuilt corridor for a match at ci_ff / vj_ff
   always_comb begin
      need_c = vc_n - N_W'(vj_ff);
      from_c = N_W'(ci_ff) + N_W'(1);
      keep_c = cc_n - from_c;
      need_p = need_c;
      keep_p = keep_c;
      if (need_c >= C_DEPTH) begin
         need_p = C_DEPTH;
         keep_p = '0;
      end else if (need_c + keep_c > C_DEPTH) begin
         keep_p = C_DEPTH - need_c;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req.kind)
                  pcm_pkg::KIND_READ:
                     state_in = rd_ok ? pcm_pkg::ST_READ : pcm_pkg::ST_DONE;
                  pcm_pkg::KIND_APPEND_VISITED:
                     state_in = (req.last && can_merge) ? pcm_pkg::ST_CRD : pcm_pkg::ST_DONE;
                  default:
                     state_in = pcm_pkg::ST_DONE;
               endcase
            end
         end
         pcm_pkg::ST_READ: state_in = pcm_pkg::ST_DONE;
         pcm_pkg::ST_CRD:  state_in = pcm_pkg::ST_VCMP;
         pcm_pkg::ST_VCMP: begin
            if (hit)
               state_in = (keep_p != '0) ? pcm_pkg::ST_MRD : pcm_pkg::ST_VRD;
            else if (vj_more)
               state_in = pcm_pkg::ST_VCMP;
            else if (ci_zero)
               state_in = pcm_pkg::ST_DONE;
            else
               state_in = pcm_pkg::ST_CRD;
         end
         pcm_pkg::ST_MRD: state_in = pcm_pkg::ST_MWR;
         pcm_pkg::ST_MWR: state_in = mv_last ? pcm_pkg::ST_VRD : pcm_pkg::ST_MRD;
         pcm_pkg::ST_VRD: state_in = pcm_pkg::ST_VWR;
         pcm_pkg::ST_VWR: state_in = vw_last ? pcm_pkg::ST_DONE : pcm_pkg::ST_VRD;
         pcm_pkg::ST_DONE: state_in = rsp_free ? pcm_pkg::ST_IDLE : pcm_pkg::ST_DONE;
         default: state_in = pcm_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cc_in         = cc_ff;
      vc_in         = vc_ff;
      ci_in         = ci_ff;
      vj_in         = vj_ff;
      need_in       = need_ff;
      keep_in       = keep_ff;
      from_in       = from_ff;
      k_in          = k_ff;
      desc_in       = desc_ff;
      drop_in       = drop_ff;
      res_entry_in  = res_entry_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cor_we = 1'b0;
      cor_re = 1'b0;
      vis_we = 1'b0;
      vis_re = 1'b0;
      cor_wa = cc_n[C_AW-1:0];
      cor_ra = ci_ff;
      cor_wd = req.poly_ref;
      vis_wa = vc_n[V_AW-1:0];
      vis_ra = vj_ff;
      vis_wd = req.poly_ref;
      case (state_ff)
         pcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_entry_in  = '0;
               res_status_in = pcm_pkg::STATUS_OK;
               drop_in       = 1'b0;
               case (req.kind)
                  pcm_pkg::KIND_APPEND_CORRIDOR: begin
                     if (!cor_full) begin
                        cor_we = 1'b1;
                        cc_in  = cc_ff + C_CW'(1);
                     end else begin
                        res_status_in = pcm_pkg::STATUS_DROP;
                     end
                  end
                  pcm_pkg::KIND_APPEND_VISITED: begin
                     if (!vis_full) begin
                        vis_we = 1'b1;
                        vc_in  = vc_ff + V_CW'(1);
                     end else begin
                        res_status_in = pcm_pkg::STATUS_DROP;
                        drop_in       = 1'b1;
                     end
                     if (req.last) begin
                        if (can_merge) begin
                           ci_in = C_AW'(cc_n - N_W'(1));
                        end else begin
                           vc_in = '0;
                           if (!vis_full)
                              res_status_in = pcm_pkg::STATUS_NOMATCH;
                        end
                     end
                  end
                  pcm_pkg::KIND_READ: begin
                     if (rd_ok) begin
                        cor_re = 1'b1;
                        cor_ra = pos_n[C_AW-1:0];
                     end else begin
                        res_status_in = pcm_pkg::STATUS_DROP;
                     end
                  end
                  default: begin
                     cc_in = '0;
                     vc_in = '0;
                  end
               endcase
            end
         end
         pcm_pkg::ST_READ: res_entry_in = cor_rd_ff;
         pcm_pkg::ST_CRD: begin
            cor_re = 1'b1;
            cor_ra = ci_ff;
            vis_re = 1'b1;
            vis_ra = '0;
            vj_in  = '0;
         end
         pcm_pkg::ST_VCMP: begin
            if (hit) begin
               need_in = need_p;
               keep_in = keep_p;
               from_in = from_c;
               desc_in = (need_p > from_c);
               k_in    = '0;
            end else if (vj_more) begin
               vis_re = 1'b1;
               vis_ra = vj_ff + V_AW'(1);
               vj_in  = vj_ff + V_AW'(1);
            end else if (ci_zero) begin
               vc_in         = '0;
               res_status_in = drop_ff ? pcm_pkg::STATUS_DROP : pcm_pkg::STATUS_NOMATCH;
            end else begin
               ci_in = ci_ff - C_AW'(1);
            end
         end
         pcm_pkg::ST_MRD: begin
            cor_re = 1'b1;
            cor_ra = mv_src[C_AW-1:0];
         end
         pcm_pkg::ST_MWR: begin
            cor_we = 1'b1;
            cor_wa = mv_dst[C_AW-1:0];
            cor_wd = cor_rd_ff;
            k_in   = mv_last ? '0 : k_ff + N_W'(1);
         end
         pcm_pkg::ST_VRD: begin
            vis_re = 1'b1;
            vis_ra = vis_src[V_AW-1:0];
         end
         pcm_pkg::ST_VWR: begin
            cor_we = 1'b1;
            cor_wa = k_ff[C_AW-1:0];
            cor_wd = vis_rd_ff;
            if (vw_last) begin
               cc_in         = new_len[C_CW-1:0];
               vc_in         = '0;
               res_status_in = drop_ff ? pcm_pkg::STATUS_DROP : pcm_pkg::STATUS_OK;
            end else begin
               k_in = k_ff + N_W'(1);
            end
         end
         pcm_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_in.corridor_length = cc_n[pcm_pkg::LEN_W-1:0];
               rsp_in.entry_value     = res_entry_ff;
               rsp_in.status          = res_status_ff;
               rsp_valid_in           = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cor_we)
         cor_mem[cor_wa] <= cor_wd;
      if (cor_re)
         cor_rd_ff <= cor_mem[cor_ra];
   end

   always_ff @(posedge clock) begin
      if (vis_we)
         vis_mem[vis_wa] <= vis_wd;
      if (vis_re)
         vis_rd_ff <= vis_mem[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcm_pkg::ST_IDLE;
         cc_ff        <= '0;
         vc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff         <= ci_in;
      vj_ff         <= vj_in;
      need_ff       <= need_in;
      keep_ff       <= keep_in;
      from_ff       <= from_in;
      k_ff          <= k_in;
      desc_ff       <= desc_in;
      drop_ff       <= drop_in;
      res_entry_ff  <= res_entry_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_cc_bound: assert property (@(posedge clock) disable iff (reset)
      cc_n <= C_DEPTH)
      else $error("corridor count beyond depth");

   a_vc_bound: assert property (@(posedge clock) disable iff (reset)
      vc_n <= V_DEPTH)
      else $error("visited count beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != pcm_pkg::ST_IDLE)
      else $error("accepted request left no work");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcm_pkg::ST_VCMP |-> N_W'(vj_ff) < vc_n)
      else $error("visited compare index out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pcm_pkg::ST_DONE)
      else $error("response raised outside completion");
`endif

endmodule

// File: tb/path_corridor_merge_tb.sv
`timescale 1ns / 100ps

module path_corridor_merge_tb;

   localparam int RANDOM_OPS     = 1750;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int POOL_SIZE      = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pcm_pkg::req_type req       = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pcm_pkg::rsp_type rsp;

   path_corridor_merge i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #2 clock = ~clock;

   // corridor and visited lists as the block should hold them
   logic [pcm_pkg::HANDLE_W-1:0] corr_mem [pcm_pkg::CORRIDOR_DEPTH];
   logic [pcm_pkg::HANDLE_W-1:0] vis_mem [pcm_pkg::VISITED_DEPTH];
   int                           corr_len = 0;
   int                           vis_len  = 0;

   pcm_pkg::req_type             path_ops[$];
   pcm_pkg::rsp_type             corridor_replies[$];
   logic [pcm_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

   int          req_count  = 0;
   int          rsp_count  = 0;
   int          mismatches = 0;
   int          req_wait   = 0;
   int          rsp_wait   = 0;
   bit          req_calm   = 1'b0;
   bit          rsp_calm   = 1'b0;
   int unsigned run_cycles;
   int unsigned hold_left;

   function automatic bit splice_visited();
      logic [pcm_pkg::HANDLE_W-1:0] fresh [pcm_pkg::CORRIDOR_DEPTH];
      int  i, j, k;
      int  hit_pos, hit_vis, need, keep, tail_from;
      bit  found;
      found   = 1'b0;
      hit_pos = 0;
      hit_vis = 0;
      // highest corridor slot first, earliest visited entry within it
      for (i = corr_len - 1; i >= 0 && !found; i--) begin
         for (j = 0; j < vis_len && !found; j++) begin
            if (corr_mem[i] == vis_mem[j]) begin
               hit_pos = i;
               hit_vis = j;
               found   = 1'b1;
            end
         end
      end
      if (!found) return 1'b0;
      need      = vis_len - hit_vis;
      tail_from = hit_pos + 1;
      keep      = corr_len - tail_from;
      if (need >= pcm_pkg::CORRIDOR_DEPTH) begin
         need = pcm_pkg::CORRIDOR_DEPTH;
         keep = 0;
      end else if (need + keep > pcm_pkg::CORRIDOR_DEPTH) begin
         keep = pcm_pkg::CORRIDOR_DEPTH - need;
      end
      for (k = 0; k < keep; k++) fresh[need + k] = corr_mem[tail_from + k];
      for (k = 0; k < need; k++) fresh[k] = vis_mem[vis_len - 1 - k];
      for (k = 0; k < need + keep; k++) corr_mem[k] = fresh[k];
      corr_len = need + keep;
      return 1'b1;
   endfunction

   function automatic pcm_pkg::rsp_type corridor_step(input pcm_pkg::req_type r);
      pcm_pkg::rsp_type o;
      o        = '0;
      o.status = pcm_pkg::STATUS_OK;
      case (r.kind)
         pcm_pkg::KIND_APPEND_CORRIDOR: begin
            if (corr_len < pcm_pkg::CORRIDOR_DEPTH) begin
               corr_mem[corr_len] = r.poly_ref;
               corr_len++;
            end else begin
               o.status = pcm_pkg::STATUS_DROP;
            end
         end
         pcm_pkg::KIND_APPEND_VISITED: begin
            if (vis_len < pcm_pkg::VISITED_DEPTH) begin
               vis_mem[vis_len] = r.poly_ref;
               vis_len++;
            end else begin
               o.status = pcm_pkg::STATUS_DROP;
            end
            if (r.last) begin
               if (!splice_visited() && o.status == pcm_pkg::STATUS_OK)
                  o.status = pcm_pkg::STATUS_NOMATCH;
               vis_len = 0;
            end
         end
         pcm_pkg::KIND_READ: begin
            if (r.position < corr_len) o.entry_value = corr_mem[r.position];
            else o.status = pcm_pkg::STATUS_DROP;
         end
         default: begin
            corr_len = 0;
            vis_len  = 0;
         end
      endcase
      o.corridor_length = pcm_pkg::LEN_W'(corr_len);
      return o;
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [pcm_pkg::HANDLE_W-1:0] pick_handle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 97) return {$urandom, $urandom};
      else if (roll < 99) return '1;
      else return '0;
   endfunction

   task automatic add_op(input logic [pcm_pkg::KIND_W-1:0] kind,
                         input logic [pcm_pkg::HANDLE_W-1:0] handle,
                         input logic [pcm_pkg::POS_W-1:0] pos, input logic last);
      pcm_pkg::req_type r;
      r.kind     = kind;
      r.poly_ref = handle;
      r.position = pos;
      r.last     = last;
      path_ops.push_back(r);
   endtask

   // request side
   always @(posedge clock) begin : drive_req
      bit holding;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            corridor_replies.push_back(corridor_step(req));
            req_count++;
            holding  = 1'b0;
            req_wait = draw_gap(req_calm);
            if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
         end
         if (!holding) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (path_ops.size() > 0) begin
               req       <= path_ops.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin : watch_rsp
      pcm_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (corridor_replies.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: len %0d value %h status %0d",
                           rsp.corridor_length, rsp.entry_value, rsp.status);
               mismatches++;
            end else begin
               want = corridor_replies.pop_front();
               if (rsp !== want) begin
                  if (mismatches < 10)
                     $display({"mismatch on response %0d: expected len %0d value %h status %0d,",
                               " got len %0d value %h status %0d"}, rsp_count,
                              want.corridor_length, want.entry_value, want.status,
                              rsp.corridor_length, rsp.entry_value, rsp.status);
                  mismatches++;
               end
            end
            rsp_wait = draw_gap(rsp_calm);
            if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
         end else if (rsp_valid && rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait > 0) || (hold_left > 0);
      end
   end

   // long receiver hold-offs so the block backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         run_cycles <= 0;
         hold_left  <= 0;
      end else begin
         run_cycles <= run_cycles + 1;
         if (run_cycles == 3000 || run_cycles == 20000) hold_left <= HOLD_CYCLES;
         else if (hold_left > 0) hold_left <= hold_left - 1;
      end
   end

   initial begin : run_test
      int  p, n, idle, seen, episode, corr_n, vis_n, reads;
      bit  deep;
      for (p = 0; p < POOL_SIZE; p++) handle_pool[p] = {$urandom, $urandom};

      // directed: empty list cases, extremes, merges with and without a match
      add_op(pcm_pkg::KIND_READ, '0, '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[0], '0, 1'b1);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, '0, '1, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, '1, '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, handle_pool[0], '0, 1'b1);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, handle_pool[1], '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, handle_pool[2], '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_CORRIDOR, handle_pool[3], '0, 1'b0);
      add_op(pcm_pkg::KIND_READ, '1, '1, 1'b1);
      add_op(pcm_pkg::KIND_READ, '1, pcm_pkg::POS_W'(1), 1'b0);
      add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'(5), 1'b0);
      // duplicate handle in the visited run: earliest copy wins
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[4], '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[1], '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[5], '0, 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[1], '1, 1'b1);
      add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'(0), 1'b0);
      add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'(4), 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, '0, '0, 1'b1);
      add_op(pcm_pkg::KIND_APPEND_VISITED, handle_pool[3], '0, 1'b1);
      add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'(0), 1'b0);
      add_op(pcm_pkg::KIND_CLEAR, '1, '1, 1'b1);
      add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'(0), 1'b0);
      add_op(pcm_pkg::KIND_APPEND_VISITED, '1, '0, 1'b0);
      add_op(pcm_pkg::KIND_CLEAR, '0, '0, 1'b0);

      // random: mostly fill corridor, visited run ending in last, with some noise
      episode = 0;
      while (path_ops.size() < RANDOM_OPS + 24) begin
         if (episode > 0 && $urandom_range(0, 99) < 8) begin
            for (n = $urandom_range(1, 4); n > 0; n--)
               add_op(pcm_pkg::KIND_W'($urandom_range(0, 3)), {$urandom, $urandom},
                      pcm_pkg::POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         end else begin
            // the first episode and some later ones are deep and can overfill both lists
            deep = (episode == 0) || ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0)
               add_op(pcm_pkg::KIND_CLEAR, {$urandom, $urandom}, pcm_pkg::POS_W'($urandom),
                      1'($urandom));
            corr_n = deep ? $urandom_range(50, 70) : $urandom_range(0, 12);
            for (n = 0; n < corr_n; n++)
               add_op(pcm_pkg::KIND_APPEND_CORRIDOR, pick_handle(),
                      pcm_pkg::POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            for (reads = $urandom_range(0, 3); reads > 0; reads--)
               add_op(pcm_pkg::KIND_READ, {$urandom, $urandom},
                      pcm_pkg::POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                 : $urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
            vis_n = (deep || $urandom_range(0, 5) == 0) ? $urandom_range(1, 20)
                                                        : $urandom_range(1, 8);
            for (n = 1; n < vis_n; n++)
               add_op(pcm_pkg::KIND_APPEND_VISITED, pick_handle(),
                      pcm_pkg::POS_W'($urandom), 1'b0);
            add_op(pcm_pkg::KIND_APPEND_VISITED, pick_handle(), pcm_pkg::POS_W'($urandom), 1'b1);
            for (reads = $urandom_range(0, 3); reads > 0; reads--)
               add_op(pcm_pkg::KIND_READ, '0, pcm_pkg::POS_W'($urandom_range(0, 20)), 1'b0);
         end
         episode++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      idle = 0;
      seen = 0;
      while (!(path_ops.size() == 0 && !req_valid && corridor_replies.size() == 0)
             && idle < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (req_count + rsp_count != seen) begin
            seen = req_count + rsp_count;
            idle = 0;
         end else begin
            idle++;
         end
      end

      if (idle >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (mismatches == 0 && corridor_replies.size() == 0) begin
            $display("RESULT: OK");
         end else begin
            $display("RESULT: ERROR");
         end
      end
      $finish;
   end

endmodule
